// ===== src/float_quantize_bit_pack_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FLOAT_QUANTIZE_BIT_PACK_DEFINES_SVH
`define FLOAT_QUANTIZE_BIT_PACK_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FQBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define FQBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/fqbp_pkg.sv =====
// ----------------------------------------------------------------------------
// fqbp_pkg
// Shared types, constants and fp32 arithmetic helpers for the quantizer.
// ----------------------------------------------------------------------------
package fqbp_pkg;

    localparam int NUM_LANES = 8;
    localparam int LANE_LAT  = 8;

    localparam logic [1:0] CFG_CODE_DEPTH = 2'd0;
    localparam logic [1:0] CFG_SCALE      = 2'd1;
    localparam logic [1:0] CFG_OFFSET     = 2'd2;
    localparam logic [1:0] CFG_HALF_INPUT = 2'd3;

    localparam logic [31:0] FP_NAN     = 32'h7FC0_0000;
    localparam logic [31:0] FP_HALF    = 32'h3F00_0000;
    localparam logic [30:0] FP_255_MAG = 31'h437F_0000;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] offset;
        logic        half;
    } t_lane_cfg;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        logic [8:0]  e;
        logic [27:0] s;
    } t_add_mid;

    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [11:0] e;
        logic [47:0]        p;
    } t_mul_mid;

    // Widen fp16 bits to fp32 bits exactly
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  k;
        logic [3:0]  sh;
        logic [10:0] m;
        logic [7:0]  e2;
        ex  = h[14:10];
        man = h[9:0];
        k   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) k = 4'(i);
        end
        sh = 4'd10 - k;
        m  = {1'b0, man} << sh;
        e2 = 8'd113 - {4'd0, sh};
        if (ex == 5'd31) begin
            return {h[15], 8'hFF, man, 13'd0};
        end else if (ex == 5'd0) begin
            if (man == 10'd0) return {h[15], 31'd0};
            return {h[15], e2, m[9:0], 13'd0};
        end
        return {h[15], ex + 8'd112, man, 13'd0};
    endfunction

    // Add: specials, operand swap, alignment and mantissa add
    function automatic t_add_mid add_pre(input logic [31:0] a, input logic [31:0] b);
        t_add_mid    r;
        logic        nan_a, nan_b, inf_a, inf_b;
        logic [31:0] x, y;
        logic [8:0]  ex, ey, d;
        logic [26:0] mx, my, al, msk;
        logic        st;
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (b[30:0] > a[30:0]) begin
            x = b; y = a;
        end else begin
            x = a; y = b;
        end
        ex = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
        ey = (y[30:23] == 8'd0) ? 9'd1 : {1'b0, y[30:23]};
        d  = ex - ey;
        mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        if (d >= 9'd27) begin
            al = 27'd0;
            st = |my;
        end else begin
            msk = (27'd1 << d[4:0]) - 27'd1;
            al  = my >> d[4:0];
            st  = |(my & msk);
        end
        al[0] = al[0] | st;
        r.s   = (x[31] == y[31]) ? ({1'b0, mx} + {1'b0, al}) : ({1'b0, mx} - {1'b0, al});
        r.sign = (r.s == 28'd0) ? (x[31] & y[31]) : x[31];
        r.e    = ex;
        r.special  = 1'b1;
        r.spec_val = FP_NAN;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
            r.spec_val = FP_NAN;
        end else if (inf_a) begin
            r.spec_val = a;
        end else if (inf_b) begin
            r.spec_val = b;
        end else begin
            r.special = 1'b0;
        end
        return r;
    endfunction

    // Add: normalize and round to nearest even
    function automatic logic [31:0] add_post(input t_add_mid r);
        logic [26:0] m;
        logic [8:0]  e, lim, sh;
        logic [4:0]  lz;
        logic        rnd;
        logic [24:0] mr;
        logic [7:0]  fe;
        if (r.special) return r.spec_val;
        if (r.s == 28'd0) return {r.sign, 31'd0};
        e = r.e;
        if (r.s[27]) begin
            m = {r.s[27:2], r.s[1] | r.s[0]};
            e = e + 9'd1;
        end else begin
            lz = 5'd0;
            for (int i = 0; i < 27; i++) begin
                if (r.s[i]) lz = 5'(26 - i);
            end
            lim = e - 9'd1;
            sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
            m   = r.s[26:0] << sh;
            e   = e - sh;
        end
        rnd = m[2] & (m[1] | m[0] | m[3]);
        mr  = {1'b0, m[26:3]} + {24'd0, rnd};
        if (mr[24]) begin
            mr = mr >> 1;
            e  = e + 9'd1;
        end
        if (e >= 9'd255) return {r.sign, 8'hFF, 23'd0};
        fe = mr[23] ? e[7:0] : 8'd0;
        return {r.sign, fe, mr[22:0]};
    endfunction

    // Multiply: specials, exponent sum and mantissa product
    function automatic t_mul_mid mul_pre(input logic [31:0] a, input logic [31:0] b);
        t_mul_mid    r;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        r.sign = a[31] ^ b[31];
        r.e    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
        r.p    = {24'd0, ma} * {24'd0, mb};
        r.special  = 1'b1;
        r.spec_val = FP_NAN;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            r.spec_val = FP_NAN;
        end else if (inf_a || inf_b) begin
            r.spec_val = {r.sign, 8'hFF, 23'd0};
        end else begin
            r.special = 1'b0;
        end
        return r;
    endfunction

    // Multiply: normalize, denormalize when tiny, round to nearest even
    function automatic logic [31:0] mul_post(input t_mul_mid r);
        logic [47:0]        q, msk;
        logic signed [11:0] e, lim, sh, rs;
        logic [5:0]         lz;
        logic               st, rnd;
        logic [24:0]        mr;
        logic [7:0]         fe;
        if (r.special) return r.spec_val;
        if (r.p == 48'd0) return {r.sign, 31'd0};
        q = r.p;
        e = r.e;
        if (q[47]) begin
            q = {1'b0, q[47:2], q[1] | q[0]};
            e = e + 12'sd1;
        end
        lz = 6'd0;
        for (int i = 0; i < 47; i++) begin
            if (q[i]) lz = 6'(46 - i);
        end
        if (e >= 12'sd1) begin
            lim = e - 12'sd1;
            sh  = ($signed({6'd0, lz}) < lim) ? $signed({6'd0, lz}) : lim;
            q   = q << sh[5:0];
            e   = e - sh;
        end else begin
            rs = 12'sd1 - e;
            if (rs >= 12'sd48) begin
                q = {47'd0, |q};
            end else begin
                msk = (48'd1 << rs[5:0]) - 48'd1;
                st  = |(q & msk);
                q   = q >> rs[5:0];
                q[0] = q[0] | st;
            end
            e = 12'sd1;
        end
        rnd = q[22] & ((|q[21:0]) | q[23]);
        mr  = {1'b0, q[46:23]} + {24'd0, rnd};
        if (mr[24]) begin
            mr = mr >> 1;
            e  = e + 12'sd1;
        end
        if (e >= 12'sd255) return {r.sign, 8'hFF, 23'd0};
        fe = mr[23] ? e[7:0] : 8'd0;
        return {r.sign, fe, mr[22:0]};
    endfunction

    // Truncate to an unsigned code, clamp to 0..255
    function automatic logic [7:0] to_code(input logic [31:0] t);
        logic [7:0]  k;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] v;
        k  = t[30:23] - 8'd127;
        m  = {1'b1, t[22:0]};
        sh = 5'd23 - k[4:0];
        v  = m >> sh;
        if ((t[30:23] == 8'hFF) && (t[22:0] != 23'd0)) return 8'd0;
        if (t[31] || (t[30:0] == 31'd0)) return 8'd0;
        if (t[30:0] >= FP_255_MAG) return 8'hFF;
        if (t[30:23] < 8'd127) return 8'd0;
        return v[7:0];
    endfunction

endpackage

// ===== src/fqbp_lane.sv =====
// ----------------------------------------------------------------------------
// fqbp_lane
// One quantizer lane: decode, subtract, multiply, add half, truncate.
// ----------------------------------------------------------------------------
module fqbp_lane (
    input  logic                i_clk,
    input  logic [31:0]         i_value,
    input  fqbp_pkg::t_lane_cfg i_cfg,
    output logic [7:0]          o_code
);

    logic [31:0]        r_val;
    fqbp_pkg::t_add_mid r_sub;
    logic [31:0]        r_diff;
    fqbp_pkg::t_mul_mid r_mul;
    logic [31:0]        r_prod;
    fqbp_pkg::t_add_mid r_add;
    logic [31:0]        r_t;
    logic [7:0]         r_code;

    // Advance one stage per cycle; payload only, no reset
    always_ff @(posedge i_clk) begin
        r_val  <= i_cfg.half ? fqbp_pkg::half_to_single(i_value[15:0]) : i_value;
        r_sub  <= fqbp_pkg::add_pre(r_val, {~i_cfg.offset[31], i_cfg.offset[30:0]});
        r_diff <= fqbp_pkg::add_post(r_sub);
        r_mul  <= fqbp_pkg::mul_pre(r_diff, i_cfg.scale);
        r_prod <= fqbp_pkg::mul_post(r_mul);
        r_add  <= fqbp_pkg::add_pre(r_prod, fqbp_pkg::FP_HALF);
        r_t    <= fqbp_pkg::add_post(r_add);
        r_code <= fqbp_pkg::to_code(r_t);
    end

    assign o_code = r_code;

endmodule

// ===== src/fqbp_merge.sv =====
// ----------------------------------------------------------------------------
// fqbp_merge
// Pack lane codes, update running sums, hold the result transaction.
// ----------------------------------------------------------------------------
module fqbp_merge (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  logic       i_last,
    input  logic [7:0] i_codes [fqbp_pkg::NUM_LANES],
    input  logic [3:0] i_depth,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [127:0] o_data,
    output logic       o_last
);

    logic [3:0]   w_depth;
    logic [7:0]   w_mask;
    logic [63:0]  w_packed;
    logic [10:0]  w_sum;
    logic [18:0]  w_sq;
    logic [31:0]  w_acc_sum, w_acc_sq;
    logic         r_valid, r_last;
    logic [127:0] r_data;
    logic [31:0]  r_acc_sum, r_acc_sq;

    // Clamp depth, pack codes and compute the running sums
    always_comb begin
        w_depth = (i_depth < 4'd4) ? 4'd4 : ((i_depth > 4'd8) ? 4'd8 : i_depth);
        w_mask  = 8'((9'd1 << w_depth) - 9'd1);
        w_packed = 64'd0;
        w_sum    = 11'd0;
        w_sq     = 19'd0;
        for (int i = 0; i < fqbp_pkg::NUM_LANES; i++) begin
            w_packed = w_packed | ({56'd0, i_codes[i] & w_mask} << (6'(i) * {2'd0, w_depth}));
            w_sum    = w_sum + {3'd0, i_codes[i]};
            w_sq     = w_sq + {3'd0, 16'({8'd0, i_codes[i]} * {8'd0, i_codes[i]})};
        end
        w_acc_sum = r_acc_sum + {21'd0, w_sum};
        w_acc_sq  = r_acc_sq + {13'd0, w_sq};
    end

    // Hold result until taken; clear sums after the last group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
            r_acc_sum <= 32'd0;
            r_acc_sq  <= 32'd0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            if (i_vld) begin
                r_valid   <= 1'b1;
                r_last    <= i_last;
                r_acc_sum <= i_last ? 32'd0 : w_acc_sum;
                r_acc_sq  <= i_last ? 32'd0 : w_acc_sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) r_data <= {w_acc_sq, w_acc_sum, w_packed};
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// ===== src/float_quantize_bit_pack.sv =====
// Each group passes the 8-stage fp lane pipeline and then the output register.
// Only one group is in flight at a time: s_axis_tready stays low from
// an accepted transaction until its result transaction completes.
// Reset (synchronous, active low) clears control, config and sum registers.
// ----------------------------------------------------------------------------
// float_quantize_bit_pack
// Eight-lane fp32/fp16 min-scale quantizer with little-endian bit packing.
// ----------------------------------------------------------------------------
module float_quantize_bit_pack (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,   // value_0 .. value_7, 32 bits each
    input  logic         s_axis_tlast,   // group_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // packed_bits, code_sum, code_square_sum
    output logic         m_axis_tlast    // result_last
);

    logic [3:0]  r_depth;
    logic [31:0] r_scale, r_offset;
    logic        r_half;
    logic        r_busy;
    logic [fqbp_pkg::LANE_LAT-1:0] r_vld, r_last;
    fqbp_pkg::t_lane_cfg w_cfg;
    logic [7:0]  w_codes [fqbp_pkg::NUM_LANES];
    logic        w_in_xact, w_out_xact;

    assign w_in_xact  = s_axis_tvalid && s_axis_tready;
    assign w_out_xact = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_busy;
    assign w_cfg = '{scale: r_scale, offset: r_offset, half: r_half};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= 4'd8;
            r_scale  <= 32'h3F80_0000;
            r_offset <= 32'd0;
            r_half   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fqbp_pkg::CFG_CODE_DEPTH: r_depth  <= i_cfg_data[3:0];
                fqbp_pkg::CFG_SCALE:      r_scale  <= i_cfg_data;
                fqbp_pkg::CFG_OFFSET:     r_offset <= i_cfg_data;
                fqbp_pkg::CFG_HALF_INPUT: r_half   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Track the transaction in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= '0;
            r_last <= '0;
        end else begin
            if (w_in_xact) r_busy <= 1'b1;
            else if (w_out_xact) r_busy <= 1'b0;
            r_vld  <= {r_vld[fqbp_pkg::LANE_LAT-2:0], w_in_xact};
            r_last <= {r_last[fqbp_pkg::LANE_LAT-2:0], s_axis_tlast};
        end
    end

    for (genvar g = 0; g < fqbp_pkg::NUM_LANES; g++) begin : g_lane
        fqbp_lane u_lane (
            .i_clk   (i_clk),
            .i_value (s_axis_tdata[g*32 +: 32]),
            .i_cfg   (w_cfg),
            .o_code  (w_codes[g])
        );
    end

    fqbp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[fqbp_pkg::LANE_LAT-1]),
        .i_last  (r_last[fqbp_pkg::LANE_LAT-1]),
        .i_codes (w_codes),
        .i_depth (r_depth),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== src/fqbp_checker.sv =====
// ----------------------------------------------------------------------------
// fqbp_checker
// Port-level checks on the quantizer handshakes.
// ----------------------------------------------------------------------------
`include "float_quantize_bit_pack_defines.svh"

module fqbp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // A pending result blocks new input
    `FQBP_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    // An accepted transaction closes the input side
    `FQBP_ASSERT_NEXT(a_in_closes, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Stalled result keeps valid
    `FQBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // Stalled result keeps its payload
    `FQBP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind float_quantize_bit_pack fqbp_checker u_fqbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
